// ----- src/tcc_pkg.sv -----
// shared types, constants and lookup functions for the temperature color chaser
package tcc_pkg;

  localparam int TEMP_W    = 8;
  localparam int CH_W      = 8;
  localparam int POS_W     = 6;
  localparam int ACC_W     = 13;
  localparam int THR_W     = 12;
  localparam int STEP_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 12;
  localparam int FRAC_W    = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_STEP       = 1'd1;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 12'd800;
  localparam logic [STEP_W-1:0] HOT_STEP_RESET  = 8'd130;
  localparam logic [STEP_W-1:0] COLD_STEP       = 8'd2;

  // temperature band limits
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = 8'sd20;
  localparam logic signed [TEMP_W-1:0] TEMP_HOT  = 8'sd80;
  // step in the band is 2 + (t - 20) = t - 18
  localparam logic signed [TEMP_W-1:0] STEP_OFFSET = 8'sd18;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  localparam rgb_t COLD_RGB = '{red: 8'd0, green: 8'd0, blue: 8'd160};
  localparam rgb_t HOT_RGB  = '{red: 8'd255, green: 8'd0, blue: 8'd0};

  // color table, one entry every 5 degrees from 20
  function automatic rgb_t hue_entry(logic [3:0] row);
    rgb_t c;
    case (row)
      4'd0:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      4'd1:    c = '{red: 8'd0,   green: 8'd128, blue: 8'd255};
      4'd2:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
      4'd3:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd128};
      4'd4:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
      4'd5:    c = '{red: 8'd128, green: 8'd255, blue: 8'd0};
      4'd6:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
      4'd7:    c = '{red: 8'd255, green: 8'd200, blue: 8'd0};
      4'd8:    c = '{red: 8'd255, green: 8'd128, blue: 8'd0};
      4'd9:    c = '{red: 8'd255, green: 8'd64,  blue: 8'd0};
      4'd10:   c = '{red: 8'd255, green: 8'd32,  blue: 8'd0};
      4'd11:   c = '{red: 8'd255, green: 8'd16,  blue: 8'd0};
      default: c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
    endcase
    return c;
  endfunction

  // seg * 32 / 5 for seg in 0..4
  function automatic logic [FRAC_W-1:0] seg_frac(logic [2:0] seg);
    logic [FRAC_W-1:0] f;
    case (seg)
      3'd0:    f = 5'd0;
      3'd1:    f = 5'd6;
      3'd2:    f = 5'd12;
      3'd3:    f = 5'd19;
      3'd4:    f = 5'd25;
      default: f = 5'd0;
    endcase
    return f;
  endfunction

endpackage

// ----- src/tcc_color.sv -----
// temperature to color mapping with linear blend between table entries
module tcc_color
  import tcc_pkg::*;
(
  input  logic signed [TEMP_W-1:0] temp_i,
  output rgb_t                     color_o
);

  // a + floor((b - a) * frac / 32), arithmetic shift gives the floor
  function automatic logic [CH_W-1:0] blend(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                            logic [FRAC_W-1:0] frac);
    logic signed [9:0]  diff;
    logic signed [15:0] prod;
    logic signed [15:0] q;
    logic signed [15:0] sum;
    diff = $signed({2'b00, b}) - $signed({2'b00, a});
    prod = 16'(diff * $signed({1'b0, frac}));
    q    = prod >>> 5;
    sum  = $signed({8'd0, a}) + q;
    return sum[CH_W-1:0];
  endfunction

  logic [5:0]        off;
  logic [9:0]        row_mul;
  logic [3:0]        row;
  logic [5:0]        five_row;
  logic [5:0]        seg_full;
  logic [FRAC_W-1:0] frac;
  rgb_t              lo_c;
  rgb_t              hi_c;
  rgb_t              mid_c;

  // offset into the band, only meaningful between 21 and 79
  assign off = 6'(temp_i - TEMP_COLD);

  // off / 5 as off * 13 / 64, exact for off below 60
  assign row_mul  = {4'd0, off} * 10'd13;
  assign row      = row_mul[9:6];
  assign five_row = {2'b00, row} * 6'd5;
  assign seg_full = off - five_row;
  assign frac     = seg_frac(seg_full[2:0]);

  // table neighbors and per channel blend
  assign lo_c = hue_entry(row);
  assign hi_c = hue_entry(row + 4'd1);

  assign mid_c.red   = blend(lo_c.red,   hi_c.red,   frac);
  assign mid_c.green = blend(lo_c.green, hi_c.green, frac);
  assign mid_c.blue  = blend(lo_c.blue,  hi_c.blue,  frac);

  // band selection
  always_comb begin
    if (temp_i <= TEMP_COLD) begin
      color_o = COLD_RGB;
    end else if (temp_i >= TEMP_HOT) begin
      color_o = HOT_RGB;
    end else begin
      color_o = mid_c;
    end
  end

endmodule

// ----- src/tcc_phase.sv -----
// phase accumulator, lit position and configuration registers
module tcc_phase
  import tcc_pkg::*;
#(
  parameter int LED_COUNT = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [TEMP_W-1:0] temp_i,
  input  logic                     upd_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  output logic [POS_W-1:0]         lit_next_o
);

  logic [THR_W-1:0]  thr_q;
  logic [STEP_W-1:0] hot_step_q;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [POS_W-1:0]  lit_q;
  logic [STEP_W-1:0] step;
  logic [ACC_W-1:0]  acc_sum;
  logic [ACC_W-1:0]  thr_ext;
  logic              hit;
  logic [POS_W:0]    lit_inc;
  logic [POS_W-1:0]  lit_wrap;

  // step grows with temperature inside the band
  always_comb begin
    if (temp_i <= TEMP_COLD) begin
      step = COLD_STEP;
    end else if (temp_i >= TEMP_HOT) begin
      step = hot_step_q;
    end else begin
      step = STEP_W'(temp_i - STEP_OFFSET);
    end
  end

  // accumulate, subtract the threshold at most once per item
  assign thr_ext = {1'b0, thr_q};
  assign acc_sum = acc_q + {5'd0, step};
  assign hit     = acc_sum >= thr_ext;
  assign acc_d   = hit ? (acc_sum - thr_ext) : acc_sum;

  // advance the lit position with wrap at the chain end
  assign lit_inc    = {1'b0, lit_q} + 7'd1;
  assign lit_wrap   = (lit_inc >= 7'(LED_COUNT)) ? '0 : lit_inc[POS_W-1:0];
  assign lit_next_o = hit ? lit_wrap : lit_q;

  // state update when an item moves on to the emitter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      lit_q <= '0;
    end else if (upd_i) begin
      acc_q <= acc_d;
      lit_q <= lit_next_o;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THRESHOLD_RESET;
      hot_step_q <= HOT_STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MOVE_THRESHOLD: thr_q      <= cfg_data_i[THR_W-1:0];
        REG_HOT_STEP:       hot_step_q <= cfg_data_i[STEP_W-1:0];
      endcase
    end
  end

endmodule

// ----- src/tcc_emit.sv -----
// frame emitter: walks the chain and shows the color on the lit led only
module tcc_emit
  import tcc_pkg::*;
#(
  parameter int LED_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  rgb_t             color_i,
  input  logic [POS_W-1:0] lit_i,
  input  logic             ready_i,
  output logic             free_o,
  output logic             valid_o,
  output logic [POS_W-1:0] led_o,
  output rgb_t             rgb_o,
  output logic             last_o
);

  localparam logic [POS_W-1:0] LastLed = POS_W'(LED_COUNT - 1);

  logic             busy_q;
  logic [POS_W-1:0] cnt_q;
  logic [POS_W-1:0] lit_q;
  rgb_t             color_q;

  assign valid_o = busy_q;
  assign led_o   = cnt_q;
  assign last_o  = (cnt_q == LastLed);
  assign rgb_o   = (cnt_q == lit_q) ? color_q : '0;

  // ready for the next frame when idle or on the final accepted item
  assign free_o = !busy_q || (ready_i && last_o);

  // frame counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && ready_i) begin
      if (last_o) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + POS_W'(1);
      end
    end
  end

  // frame payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lit_q   <= lit_i;
      color_q <= color_i;
    end
  end

endmodule

// ----- src/temperature_color_chaser.sv -----
// top level of the temperature color chaser
//
// Input channel s_axis carries one temperature update per item (signed degrees
// in tdata[7:0]). Output channel m_axis carries LED_COUNT items per update, one
// per led in chain order, with tlast on the final led. Only the lit led shows
// the color picked from the temperature; all others are black.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 move threshold, 1 hot step); write only while the block is idle.
// The first led item of an update becomes valid once the update has passed
// the input register and has been loaded into the frame emitter; it waits in
// the input register while the emitter is still busy with the previous frame.
// The emitter sends one led item per cycle while the receiver is ready; the
// next update waits in the input register and follows the final led of the
// previous frame without a gap.
// Reset clears the accumulator and the lit position and loads the register
// defaults (threshold 800, hot step 130); no item is pending after reset.
// When the receiver stalls, the current led item holds and at most one more
// update is taken into the input register.
module temperature_color_chaser
  import tcc_pkg::*;
#(
  parameter int LED_COUNT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] temperature
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // [5:0] led_number, [13:6] red,
                                               // [21:14] green, [29:22] blue
  output logic                 m_axis_tlast,   // last_led
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic                     in_valid_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic                     s_fire;
  logic                     m_fire;
  logic                     load;
  logic                     emit_free;
  rgb_t                     color;
  logic [POS_W-1:0]         lit_next;
  logic [POS_W-1:0]         led;
  rgb_t                     rgb;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign load          = in_valid_q && emit_free;
  assign s_axis_tready = !in_valid_q || load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      temp_q <= $signed(s_axis_tdata);
    end
  end

  // color mapping
  tcc_color u_color (
    .temp_i  (temp_q),
    .color_o (color)
  );

  // accumulator and lit position, updated as the item enters the emitter
  tcc_phase #(
    .LED_COUNT (LED_COUNT)
  ) u_phase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .temp_i     (temp_q),
    .upd_i      (load),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .lit_next_o (lit_next)
  );

  // frame emitter
  tcc_emit #(
    .LED_COUNT (LED_COUNT)
  ) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .color_i (color),
    .lit_i   (lit_next),
    .ready_i (m_axis_tready),
    .free_o  (emit_free),
    .valid_o (m_axis_tvalid),
    .led_o   (led),
    .rgb_o   (rgb),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, rgb.blue, rgb.green, rgb.red, led};

  // led numbers advance by one inside a frame
  a_led_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && !m_axis_tlast) |=>
      (m_axis_tvalid && (m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1)))
    else $error("led number did not advance within a frame");

  // a waiting update starts a new frame right after the final led
  a_frame_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast && in_valid_q) |=>
      (m_axis_tvalid && (m_axis_tdata[5:0] == 6'd0)))
    else $error("pending update did not start a frame at led zero");

  // with nothing waiting the output goes idle after the final led
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast && !in_valid_q) |=> !m_axis_tvalid)
    else $error("output stayed valid after the final led");

  // lit position stays inside the chain
  a_lit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ({1'b0, lit_next} < (POS_W + 1)'(LED_COUNT)))
    else $error("lit position outside the chain");

endmodule
